### design/alu_181_style_16bit_assert.svh
// ----------------------------------------------------------------------------
// alu_181_style_16bit_assert.svh - assertion macros
// Shared macros for the concurrent checks on the 16-bit ALU block.
// ----------------------------------------------------------------------------
`ifndef ALU_181_STYLE_16BIT_ASSERT_SVH
`define ALU_181_STYLE_16BIT_ASSERT_SVH

// Same-cycle implication, ignored while reset is asserted.
`define A181_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ALU check failed: same-cycle implication");

// Next-cycle implication, ignored while reset is asserted.
`define A181_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ALU check failed: next-cycle implication");

// Condition that must hold in the cycle after reset is seen.
`define A181_ASSERT_RST(lbl, cons) \
  lbl: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
    else $error("ALU check failed: state after reset");

`endif

### design/alu181_pkg.sv
// ----------------------------------------------------------------------------
// alu181_pkg - shared types and codes
// Operation and result word layouts and the function codes of both modes.
// ----------------------------------------------------------------------------
package alu181_pkg;

  localparam int unsigned DataW = 16;
  localparam int unsigned ExactW = DataW + 2;

  // Logic-mode function codes.
  localparam logic [3:0] LF_NOT_A     = 4'd0;
  localparam logic [3:0] LF_NAND      = 4'd1;
  localparam logic [3:0] LF_NA_OR_B   = 4'd2;
  localparam logic [3:0] LF_ONE       = 4'd3;
  localparam logic [3:0] LF_NOR       = 4'd4;
  localparam logic [3:0] LF_NOT_B     = 4'd5;
  localparam logic [3:0] LF_XNOR      = 4'd6;
  localparam logic [3:0] LF_A_OR_NB   = 4'd7;
  localparam logic [3:0] LF_NA_AND_B  = 4'd8;
  localparam logic [3:0] LF_XOR       = 4'd9;
  localparam logic [3:0] LF_B         = 4'd10;
  localparam logic [3:0] LF_OR        = 4'd11;
  localparam logic [3:0] LF_ZERO      = 4'd12;
  localparam logic [3:0] LF_A_AND_NB  = 4'd13;
  localparam logic [3:0] LF_AND       = 4'd14;
  localparam logic [3:0] LF_A         = 4'd15;

  // Arithmetic-mode function codes.
  localparam logic [3:0] AF_A_DEC       = 4'd0;
  localparam logic [3:0] AF_AB_DEC      = 4'd1;
  localparam logic [3:0] AF_ANB_DEC     = 4'd2;
  localparam logic [3:0] AF_MINUS_ONE   = 4'd3;
  localparam logic [3:0] AF_A_PLUS_AONB = 4'd4;
  localparam logic [3:0] AF_AB_PLUS_AONB = 4'd5;
  localparam logic [3:0] AF_SUB         = 4'd6;
  localparam logic [3:0] AF_AONB        = 4'd7;
  localparam logic [3:0] AF_A_PLUS_AOB  = 4'd8;
  localparam logic [3:0] AF_ADD         = 4'd9;
  localparam logic [3:0] AF_ANB_PLUS_AOB = 4'd10;
  localparam logic [3:0] AF_AOB         = 4'd11;
  localparam logic [3:0] AF_DOUBLE      = 4'd12;
  localparam logic [3:0] AF_AB_PLUS_A   = 4'd13;
  localparam logic [3:0] AF_ANB_PLUS_A  = 4'd14;
  localparam logic [3:0] AF_A_INC       = 4'd15;

  typedef struct packed {
    logic [3:0]       func;
    logic             logic_mode;
    logic             carry_in;
    logic [DataW-1:0] operand_b;
    logic [DataW-1:0] operand_a;
  } op_t;

  typedef struct packed {
    logic             carry_flag;
    logic             sign_flag;
    logic             zero_flag;
    logic [DataW-1:0] result;
  } res_t;

endpackage

### design/alu181_pipe_reg.sv
// ----------------------------------------------------------------------------
// alu181_pipe_reg - one valid/ready register stage
// Holds one word; takes a new one whenever it is empty or being emptied.
// ----------------------------------------------------------------------------
module alu181_pipe_reg #(
  parameter int unsigned W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         s_valid,
  output logic         s_ready,
  input  logic [W-1:0] s_data,
  output logic         m_valid,
  input  logic         m_ready,
  output logic [W-1:0] m_data
);

  logic         valid_r;
  logic         valid_nxt;
  logic [W-1:0] data_r;

  assign s_ready = !valid_r || m_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (s_ready) begin
      valid_nxt = s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s_valid && s_ready) begin
      data_r <= s_data;
    end
  end

  assign m_valid = valid_r;
  assign m_data  = data_r;

endmodule

### design/alu181_core.sv
// ----------------------------------------------------------------------------
// alu181_core - function unit
// Forms the exact 18-bit signed value of the chosen function and its flags.
// ----------------------------------------------------------------------------
module alu181_core (
  input  alu181_pkg::op_t  op,
  output alu181_pkg::res_t res
);
  import alu181_pkg::*;

  logic [DataW-1:0]  a, b;
  logic [DataW-1:0]  lv;
  logic              lneg;
  logic [ExactW-1:0] x, y;
  logic [ExactW-1:0] arith_val;
  logic [ExactW-1:0] exact_val;
  logic [ExactW-1:0] ext_a, ext_ab, ext_anb, ext_aob, ext_b;
  logic [ExactW-1:0] neg_aonb, neg_nb, minus_one;

  assign a = op.operand_a;
  assign b = op.operand_b;

  // Operands as 18-bit two's complement; a complemented value is negative.
  assign ext_a     = {2'b00, a};
  assign ext_ab    = {2'b00, a & b};
  assign ext_anb   = {2'b00, a & ~b};
  assign ext_aob   = {2'b00, a | b};
  assign ext_b     = {2'b00, b};
  assign neg_aonb  = {2'b11, a | ~b};
  assign neg_nb    = {2'b11, ~b};
  assign minus_one = {ExactW{1'b1}};

  always_comb begin
    lv   = '0;
    lneg = 1'b0;
    unique case (op.func)
      LF_NOT_A:    begin lv = ~a;        lneg = 1'b1; end
      LF_NAND:     begin lv = ~(a & b);  lneg = 1'b1; end
      LF_NA_OR_B:  begin lv = ~a | b;    lneg = 1'b1; end
      LF_ONE:      lv = DataW'(1);
      LF_NOR:      begin lv = ~(a | b);  lneg = 1'b1; end
      LF_NOT_B:    begin lv = ~b;        lneg = 1'b1; end
      LF_XNOR:     begin lv = ~(a ^ b);  lneg = 1'b1; end
      LF_A_OR_NB:  begin lv = a | ~b;    lneg = 1'b1; end
      LF_NA_AND_B: lv = ~a & b;
      LF_XOR:      lv = a ^ b;
      LF_B:        lv = b;
      LF_OR:       lv = a | b;
      LF_ZERO:     lv = '0;
      LF_A_AND_NB: lv = a & ~b;
      LF_AND:      lv = a & b;
      LF_A:        lv = a;
    endcase
  end

  always_comb begin
    x = '0;
    y = '0;
    unique case (op.func)
      AF_A_DEC:        begin x = ext_a;   y = minus_one; end
      AF_AB_DEC:       begin x = ext_ab;  y = minus_one; end
      AF_ANB_DEC:      begin x = ext_anb; y = minus_one; end
      AF_MINUS_ONE:    begin x = '0;      y = minus_one; end
      AF_A_PLUS_AONB:  begin x = ext_a;   y = neg_aonb;  end
      AF_AB_PLUS_AONB: begin x = ext_ab;  y = neg_aonb;  end
      AF_SUB:          begin x = ext_a;   y = neg_nb;    end
      AF_AONB:         begin x = '0;      y = neg_aonb;  end
      AF_A_PLUS_AOB:   begin x = ext_a;   y = ext_aob;   end
      AF_ADD:          begin x = ext_a;   y = ext_b;     end
      AF_ANB_PLUS_AOB: begin x = ext_anb; y = ext_aob;   end
      AF_AOB:          begin x = '0;      y = ext_aob;   end
      AF_DOUBLE:       begin x = ext_a;   y = ext_a;     end
      AF_AB_PLUS_A:    begin x = ext_ab;  y = ext_a;     end
      AF_ANB_PLUS_A:   begin x = ext_anb; y = ext_a;     end
      AF_A_INC:        begin x = ext_a;   y = '0;        end
    endcase
  end

  // The exact value always lies in -65536..131071, so 18 bits never wrap.
  assign arith_val = x + y + {{(ExactW-1){1'b0}}, op.carry_in};
  assign exact_val = op.logic_mode ? {lneg, lneg, lv} : arith_val;

  assign res.result     = exact_val[DataW-1:0];
  assign res.zero_flag  = (exact_val[DataW-1:0] == '0);
  assign res.sign_flag  = exact_val[DataW-1];
  assign res.carry_flag = exact_val[ExactW-1] | exact_val[DataW];

endmodule

### design/alu_181_style_16bit.sv
// ----------------------------------------------------------------------------
// alu_181_style_16bit - 16-bit ALU in the 181 pattern
// Registered operation word, one pass of function logic, registered result.
// ----------------------------------------------------------------------------
// Channel  Dir  tdata (low bit up)                         tuser
// in_      in   operand_a, operand_b, carry_in, pad to 40  logic_mode, func
// out_     out  result, zero_flag, sign_flag, carry_flag,  -
//               pad to 24
//
// Every word accepted on in_ produces exactly one word on out_. A new word can
// be accepted every cycle while out_ is not stalled. The word passes two
// register stages: the operation register and the result register, with
// the function unit between them.
// Reset (rst_n low, synchronous) empties both stages; no result is pending
// afterwards. When out_tready is low, the result stage holds its word and the
// operation stage still takes one more word, so in_tready drops only once
// both stages are full.
// ----------------------------------------------------------------------------
module alu_181_style_16bit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [15:0] operand_a, [31:16] operand_b, [32] carry_in, [39:33] zero
  input  logic [39:0] in_tdata,
  // [0] logic_mode, [4:1] func
  input  logic [4:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [15:0] result, [16] zero_flag, [17] sign_flag, [18] carry_flag, [23:19] zero
  output logic [23:0] out_tdata
);
  import alu181_pkg::*;

  op_t  in_op;
  op_t  op_q;
  res_t res_d;
  res_t res_q;
  logic op_valid;
  logic op_ready;

  // Unpack the incoming word into the operation layout.
  assign in_op.operand_a  = in_tdata[15:0];
  assign in_op.operand_b  = in_tdata[31:16];
  assign in_op.carry_in   = in_tdata[32];
  assign in_op.logic_mode = in_tuser[0];
  assign in_op.func       = in_tuser[4:1];

  // Operation register.
  alu181_pipe_reg #(
    .W($bits(op_t))
  ) u_op_stage (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (in_tvalid),
    .s_ready (in_tready),
    .s_data  (in_op),
    .m_valid (op_valid),
    .m_ready (op_ready),
    .m_data  (op_q)
  );

  // Function unit: one pass of combinational logic.
  alu181_core u_core (
    .op  (op_q),
    .res (res_d)
  );

  // Result register.
  alu181_pipe_reg #(
    .W($bits(res_t))
  ) u_res_stage (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (op_valid),
    .s_ready (op_ready),
    .s_data  (res_d),
    .m_valid (out_tvalid),
    .m_ready (out_tready),
    .m_data  (res_q)
  );

  assign out_tdata = {5'b00000, res_q};

endmodule

### design/alu181_checker.sv
// ----------------------------------------------------------------------------
// alu181_checker - port-level checks
// Watches the ALU ports over time and flags inconsistent results.
// ----------------------------------------------------------------------------
`include "alu_181_style_16bit_assert.svh"

module alu181_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);

  // Nothing may be pending once reset has been seen.
  `A181_ASSERT_RST(a_rst_empty, !out_tvalid)

  // A stalled result stays put.
  `A181_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  // Zero and sign flags agree with the result they travel with.
  `A181_ASSERT_IMPL(a_zero_flag, out_tvalid, out_tdata[16] == (out_tdata[15:0] == 16'h0000))
  `A181_ASSERT_IMPL(a_sign_flag, out_tvalid, out_tdata[17] == out_tdata[15])

  // A draining output never back-pressures the input.
  `A181_ASSERT_IMPL(a_no_stall, out_tready, in_tready)

endmodule

bind alu_181_style_16bit alu181_checker u_alu181_checker (.*);
